// ===== rtl/sext_pkg.sv =====
// shared constants, types and the edit classifier for the seed extension edit checker
package sext_pkg;

  localparam int READ_DEPTH = 256;
  localparam int REF_DEPTH  = 256;
  localparam int LOOKAHEAD  = 5;
  localparam int READ_AW    = $clog2(READ_DEPTH);
  localparam int REF_AW     = $clog2(REF_DEPTH);

  localparam int BYTE_W  = 8;
  localparam int POS_W   = 8;
  localparam int RLEN_W  = 9;
  localparam int SLEN_W  = 7;
  localparam int THR_W   = 4;
  localparam int MODE_W  = 2;
  localparam int PROD_W  = POS_W + SLEN_W;
  localparam int RI_W    = PROD_W + 2;
  localparam int FI_W    = 11;
  localparam int STEP_W  = POS_W + 1;
  localparam int CNT_W   = $clog2(LOOKAHEAD + 2);
  localparam int CMP_W   = CNT_W + THR_W;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 8;
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;
  localparam int REG_IDX_W  = APB_AW - 2;

  localparam logic [BYTE_W-1:0] SEPARATOR = 8'h58;

  localparam logic [MODE_W-1:0] MODE_LOAD_READ = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_REF  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_START     = 2'd2;

  localparam int REG_SEED_LENGTH    = 0;
  localparam int REG_EDIT_THRESHOLD = 1;

  localparam logic [SLEN_W-1:0] SEED_LENGTH_RST    = 7'd5;
  localparam logic [THR_W-1:0]  EDIT_THRESHOLD_RST = 4'd3;

  typedef enum logic [1:0] {
    EDIT_MIS,
    EDIT_INS,
    EDIT_DEL
  } edit_kind_t;

  typedef struct packed {
    logic              start;
    logic [RLEN_W-1:0] read_length;
    logic [POS_W-1:0]  seed_bin;
    logic [POS_W-1:0]  match_position;
  } sext_cmd_t;

  typedef struct packed {
    logic             idle;
    logic             done;
    logic             found;
    logic [POS_W-1:0] guide_position;
  } sext_res_t;

  function automatic edit_kind_t classify(
    input logic [CNT_W-1:0] mis,
    input logic [CNT_W-1:0] ins,
    input logic [CNT_W-1:0] del,
    input logic [CNT_W-1:0] span,
    input logic [THR_W-1:0] thr
  );
    logic [CNT_W-1:0] dm;
    logic [CNT_W-1:0] di;
    logic [CNT_W-1:0] dd;
    edit_kind_t       kind;
    dm = span - mis;
    di = span - ins;
    dd = span - del;
    if (mis >= ins && mis >= del && CMP_W'(dm) <= CMP_W'(thr)) begin
      kind = EDIT_MIS;
    end else if (ins > mis && ins > del && CMP_W'(di) <= CMP_W'(thr)) begin
      kind = EDIT_INS;
    end else if (del > mis && del > ins && CMP_W'(dd) <= CMP_W'(thr)) begin
      kind = EDIT_DEL;
    end else begin
      kind = EDIT_MIS;
    end
    return kind;
  endfunction

endpackage

// ===== rtl/sext_ram.sv =====
// byte store with one write port and one registered read port
module sext_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [sext_pkg::BYTE_W-1:0] wdata,
  input  logic [AW-1:0]               raddr,
  output logic [sext_pkg::BYTE_W-1:0] rdata
);

  logic [sext_pkg::BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/sext_seq.sv =====
// extension sequencer: walks both stores one base per step with a shared compare unit
module sext_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  sext_pkg::sext_cmd_t           cmd,
  input  logic [sext_pkg::SLEN_W-1:0]   seed_length,
  input  logic [sext_pkg::THR_W-1:0]    edit_threshold,
  input  logic                          res_take,
  input  logic [sext_pkg::BYTE_W-1:0]   rd_q,
  input  logic [sext_pkg::BYTE_W-1:0]   rf_q,
  output logic [sext_pkg::READ_AW-1:0]  rd_addr,
  output logic [sext_pkg::REF_AW-1:0]   rf_addr,
  output sext_pkg::sext_res_t           res
);

  localparam int RI_W   = sext_pkg::RI_W;
  localparam int FI_W   = sext_pkg::FI_W;
  localparam int CNT_W  = sext_pkg::CNT_W;
  localparam int THR_W  = sext_pkg::THR_W;
  localparam int STEP_W = sext_pkg::STEP_W;
  localparam int PROD_W = sext_pkg::PROD_W;
  localparam int SUM_W  = STEP_W + 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_DN_RD,
    S_DN_EV,
    S_LA_RD,
    S_LA_EV,
    S_CLASS,
    S_UP_INIT_RD,
    S_UP_INIT_EV,
    S_UP_RD,
    S_UP_EV,
    S_DONE
  } state_t;

  state_t                         state;
  logic                           up;
  logic [sext_pkg::RLEN_W-1:0]    rlen;
  logic [sext_pkg::POS_W-1:0]     bin;
  logic [sext_pkg::POS_W-1:0]     mpos;
  logic [PROD_W-1:0]              bs;
  logic [PROD_W-1:0]              prod;
  logic signed [RI_W-1:0]         ri;
  logic signed [RI_W-1:0]         la_ri;
  logic signed [RI_W-1:0]         rd_pos;
  logic signed [RI_W-1:0]         rlen_s;
  logic signed [FI_W-1:0]         fi;
  logic signed [FI_W-1:0]         la_fi;
  logic signed [FI_W-1:0]         rf_pos;
  logic [STEP_W-1:0]              j;
  logic [STEP_W-1:0]              k;
  logic [THR_W-1:0]               total;
  logic [CNT_W-1:0]               n;
  logic [CNT_W-1:0]               mis;
  logic [CNT_W-1:0]               ins;
  logic [CNT_W-1:0]               del;
  logic [CNT_W-1:0]               span;
  logic [sext_pkg::BYTE_W-1:0]    win0;
  logic [sext_pkg::BYTE_W-1:0]    win1;
  logic [sext_pkg::BYTE_W-1:0]    last_ref;
  logic [sext_pkg::BYTE_W-1:0]    rd_byte;
  logic [sext_pkg::BYTE_W-1:0]    rf_byte;
  logic                           rd_oob;
  logic                           rf_oob;
  logic                           rd_oob_q;
  logic                           rf_oob_q;
  logic                           base_eq;
  logic                           hit_mis;
  logic                           hit_ins;
  logic                           hit_del;
  logic                           ri_in_read;
  logic                           la_in_read;
  logic                           la_go;
  logic                           stop;
  logic                           ok;
  sext_pkg::edit_kind_t           kind;

  // store addressing, out of range reads as separator
  always_comb begin
    rd_pos = ri;
    rf_pos = fi;
    unique case (state)
      S_LA_RD: begin
        rd_pos = la_ri;
        rf_pos = la_fi;
      end
      S_UP_INIT_RD: rf_pos = FI_W'(mpos);
      default: ;
    endcase
  end

  assign rd_oob  = rd_pos[RI_W-1] || (rd_pos >= RI_W'(sext_pkg::READ_DEPTH));
  assign rf_oob  = rf_pos[FI_W-1] || (rf_pos >= FI_W'(sext_pkg::REF_DEPTH));
  assign rd_addr = rd_pos[sext_pkg::READ_AW-1:0];
  assign rf_addr = rf_pos[sext_pkg::REF_AW-1:0];
  assign rd_byte = rd_oob_q ? sext_pkg::SEPARATOR : rd_q;
  assign rf_byte = rf_oob_q ? sext_pkg::SEPARATOR : rf_q;

  // shared compare unit
  assign base_eq = rd_byte == rf_byte;
  assign hit_mis = up ? (rd_byte == win1) : (rd_byte == rf_byte);
  assign hit_ins = up ? (rd_byte == win0) : (rd_byte == win1);
  assign hit_del = up ? (rd_byte == rf_byte) : (win0 == rf_byte);

  assign prod       = PROD_W'(bin) * PROD_W'(seed_length);
  assign rlen_s     = $signed(RI_W'(rlen));
  assign ri_in_read = ri < rlen_s;
  assign la_in_read = up ? !la_ri[RI_W-1] : (la_ri < rlen_s);
  assign la_go      = (n < CNT_W'(sext_pkg::LOOKAHEAD)) && la_in_read &&
                      (!up || (win1 != sext_pkg::SEPARATOR));
  assign stop       = total >= edit_threshold;
  assign span       = up ? n : n + CNT_W'(1);
  assign kind       = sext_pkg::classify(mis, ins, del, span, edit_threshold);
  assign ok         = ((SUM_W'(j) + SUM_W'(k)) > SUM_W'(2)) && (total < edit_threshold);

  always_comb begin
    res.idle           = state == S_IDLE;
    res.done           = state == S_DONE;
    res.found          = ok;
    res.guide_position = ok ? mpos : '0;
  end

  always_ff @(posedge clk) begin
    rd_oob_q <= rd_oob;
    rf_oob_q <= rf_oob;
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.start) begin
            rlen  <= cmd.read_length;
            bin   <= cmd.seed_bin;
            mpos  <= cmd.match_position;
            total <= '0;
            j     <= '0;
            k     <= '0;
            up    <= 1'b0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          bs    <= prod;
          ri    <= RI_W'(prod) + RI_W'(seed_length);
          fi    <= FI_W'(mpos) + FI_W'(seed_length);
          state <= S_DN_RD;
        end
        S_DN_RD: begin
          state <= stop ? S_UP_INIT_RD : S_DN_EV;
        end
        S_DN_EV: begin
          if (rf_byte == sext_pkg::SEPARATOR) begin
            state <= S_UP_INIT_RD;
          end else if (ri_in_read && !base_eq) begin
            n     <= '0;
            mis   <= '0;
            ins   <= '0;
            del   <= '0;
            win0  <= rd_byte;
            win1  <= rf_byte;
            la_ri <= ri + RI_W'(1);
            la_fi <= fi + FI_W'(1);
            state <= S_LA_RD;
          end else begin
            if (!ri_in_read) begin
              total <= total + THR_W'(1);
            end
            j     <= j + STEP_W'(1);
            ri    <= ri + RI_W'(1);
            fi    <= fi + FI_W'(1);
            state <= S_DN_RD;
          end
        end
        S_LA_RD: begin
          state <= la_go ? S_LA_EV : S_CLASS;
        end
        S_LA_EV: begin
          if (!up && rf_byte == sext_pkg::SEPARATOR) begin
            state <= S_CLASS;
          end else begin
            mis   <= mis + CNT_W'(hit_mis);
            ins   <= ins + CNT_W'(hit_ins);
            del   <= del + CNT_W'(hit_del);
            win0  <= up ? win1 : rd_byte;
            win1  <= rf_byte;
            n     <= n + CNT_W'(1);
            la_ri <= up ? la_ri - RI_W'(1) : la_ri + RI_W'(1);
            la_fi <= up ? la_fi - FI_W'(1) : la_fi + FI_W'(1);
            state <= S_LA_RD;
          end
        end
        S_CLASS: begin
          total <= total + THR_W'(1);
          if (up) begin
            k  <= k + STEP_W'(1);
            fi <= fi - FI_W'(1);
            unique case (kind)
              sext_pkg::EDIT_INS: ri <= ri - RI_W'(2);
              sext_pkg::EDIT_DEL: ri <= ri;
              default:            ri <= ri - RI_W'(1);
            endcase
            state <= S_UP_RD;
          end else begin
            j  <= j + STEP_W'(1);
            fi <= fi + FI_W'(1);
            unique case (kind)
              sext_pkg::EDIT_INS: ri <= ri + RI_W'(2);
              sext_pkg::EDIT_DEL: ri <= ri;
              default:            ri <= ri + RI_W'(1);
            endcase
            state <= S_DN_RD;
          end
        end
        S_UP_INIT_RD: begin
          ri    <= RI_W'(bs) - RI_W'(1);
          fi    <= FI_W'(mpos) - FI_W'(1);
          up    <= 1'b1;
          state <= S_UP_INIT_EV;
        end
        S_UP_INIT_EV: begin
          last_ref <= rf_byte;
          state    <= S_UP_RD;
        end
        S_UP_RD: begin
          state <= stop ? S_DONE : S_UP_EV;
        end
        S_UP_EV: begin
          if (rf_byte == sext_pkg::SEPARATOR) begin
            state <= S_DONE;
          end else begin
            last_ref <= rf_byte;
            if (!ri[RI_W-1] && !base_eq) begin
              n     <= '0;
              mis   <= '0;
              ins   <= '0;
              del   <= '0;
              win0  <= last_ref;
              win1  <= rf_byte;
              la_ri <= ri;
              la_fi <= fi - FI_W'(1);
              state <= S_LA_RD;
            end else begin
              if (ri[RI_W-1]) begin
                total <= total + THR_W'(1);
              end
              k     <= k + STEP_W'(1);
              ri    <= ri - RI_W'(1);
              fi    <= fi - FI_W'(1);
              state <= S_UP_RD;
            end
          end
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/seed_extension_edit_checker_core.sv =====
// top level of the seed extension edit checker: stream ports, register port, stores, output stage
//
// Load items (read byte or reference byte) are taken back to back while the block is idle
// and give no result. A start item gives one result: its work takes setup and hand-off, a
// turn at each end of the walk, a store read and compare for each base downstream and
// upstream, and for each differing base a classify step plus a read and compare per
// lookahead base (at most 5). Both stores have one read port with registered data, and
// every base and lookahead step goes through that port pair and one compare unit, so the
// cost per base is set by the store read latency. Input is not taken while a start item
// is at work.
// The result waits in an output register, so the next item can be taken while it is held.
module seed_extension_edit_checker_core (
  input  logic                              clk,
  input  logic                              rst,
  // load_address[7:0], base_byte[15:8], read_length[24:16], seed_bin[32:25],
  // match_position[40:33], zero fill
  input  logic [sext_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // mode[1:0]
  input  logic [sext_pkg::MODE_W-1:0]       s_axis_tuser,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // guide_position[7:0]
  output logic [sext_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // found[0]
  output logic                              m_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sext_pkg::APB_AW-1:0]       paddr,
  input  logic [sext_pkg::APB_DW-1:0]       pwdata,
  output logic [sext_pkg::APB_DW-1:0]       prdata,
  output logic                              pready
);

  localparam int REG_IDX_W = sext_pkg::REG_IDX_W;

  logic [sext_pkg::SLEN_W-1:0]  seed_length;
  logic [sext_pkg::THR_W-1:0]   edit_threshold;
  logic [REG_IDX_W-1:0]         reg_idx;
  logic                         cfg_write;
  logic                         in_accept;
  logic [sext_pkg::POS_W-1:0]   load_address;
  logic [sext_pkg::BYTE_W-1:0]  base_byte;
  logic                         addr_in_read;
  logic                         addr_in_ref;
  logic                         read_we;
  logic                         ref_we;
  logic [sext_pkg::READ_AW-1:0] rd_addr;
  logic [sext_pkg::REF_AW-1:0]  rf_addr;
  logic [sext_pkg::BYTE_W-1:0]  rd_q;
  logic [sext_pkg::BYTE_W-1:0]  rf_q;
  logic                         res_take;
  sext_pkg::sext_cmd_t          cmd;
  sext_pkg::sext_res_t          res;

  // register port
  assign pready    = 1'b1;
  assign reg_idx   = paddr[sext_pkg::APB_AW-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    if (reg_idx == REG_IDX_W'(sext_pkg::REG_EDIT_THRESHOLD)) begin
      prdata = sext_pkg::APB_DW'(edit_threshold);
    end else begin
      prdata = sext_pkg::APB_DW'(seed_length);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_length    <= sext_pkg::SEED_LENGTH_RST;
      edit_threshold <= sext_pkg::EDIT_THRESHOLD_RST;
    end else if (cfg_write) begin
      if (reg_idx == REG_IDX_W'(sext_pkg::REG_EDIT_THRESHOLD)) begin
        edit_threshold <= pwdata[sext_pkg::THR_W-1:0];
      end else begin
        seed_length <= pwdata[sext_pkg::SLEN_W-1:0];
      end
    end
  end

  // input items
  assign s_axis_tready = res.idle;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign load_address  = s_axis_tdata[7:0];
  assign base_byte     = s_axis_tdata[15:8];
  assign addr_in_read  = 32'(load_address) < sext_pkg::READ_DEPTH;
  assign addr_in_ref   = 32'(load_address) < sext_pkg::REF_DEPTH;
  assign read_we = in_accept && (s_axis_tuser == sext_pkg::MODE_LOAD_READ) && addr_in_read;
  assign ref_we  = in_accept && (s_axis_tuser == sext_pkg::MODE_LOAD_REF) && addr_in_ref;

  always_comb begin
    cmd.start          = in_accept && (s_axis_tuser == sext_pkg::MODE_START);
    cmd.read_length    = s_axis_tdata[24:16];
    cmd.seed_bin       = s_axis_tdata[32:25];
    cmd.match_position = s_axis_tdata[40:33];
  end

  sext_ram #(
    .DEPTH (sext_pkg::READ_DEPTH)
  ) u_read_ram (
    .clk   (clk),
    .we    (read_we),
    .waddr (load_address[sext_pkg::READ_AW-1:0]),
    .wdata (base_byte),
    .raddr (rd_addr),
    .rdata (rd_q)
  );

  sext_ram #(
    .DEPTH (sext_pkg::REF_DEPTH)
  ) u_ref_ram (
    .clk   (clk),
    .we    (ref_we),
    .waddr (load_address[sext_pkg::REF_AW-1:0]),
    .wdata (base_byte),
    .raddr (rf_addr),
    .rdata (rf_q)
  );

  sext_seq u_seq (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .seed_length    (seed_length),
    .edit_threshold (edit_threshold),
    .res_take       (res_take),
    .rd_q           (rd_q),
    .rf_q           (rf_q),
    .rd_addr        (rd_addr),
    .rf_addr        (rf_addr),
    .res            (res)
  );

  // output register
  assign res_take = res.done && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_take) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (res_take) begin
      m_axis_tdata <= res.guide_position;
      m_axis_tuser <= res.found;
    end
  end

`ifndef ASSERT_OFF
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == sext_pkg::MODE_START)
    |=> !s_axis_tready)
    else $error("start item did not make the block busy");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("result without a match carries a nonzero position");

  a_take_room: assert property (@(posedge clk) disable iff (rst)
    res_take |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result handed over while the output register was full");
`endif

endmodule

// ===== bench/tb_seed_extension_edit_checker_core.sv =====
// testbench for seed_extension_edit_checker_core: random stream stimulus, self-checking predictor
module tb_seed_extension_edit_checker_core;
  timeunit 1ns;
  timeprecision 1ps;

  import sext_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int LIMIT       = 3_000_000;
  localparam int SETTLE      = 16;
  localparam int TAIL        = 300;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [7:0]        load_address;
    logic [7:0]        base_byte;
    logic [8:0]        read_length;
    logic [7:0]        seed_bin;
    logic [7:0]        match_position;
  } stim_item_t;

  typedef struct packed {
    logic       found;
    logic [7:0] guide_position;
  } guide_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [MODE_W-1:0]     s_axis_tuser = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_AW-1:0]     paddr = '0;
  logic [APB_DW-1:0]     pwdata = '0;
  logic [APB_DW-1:0]     prdata;
  logic                  pready;

  stim_item_t  stim_items[$];
  guide_t      pending_guides[$];
  stim_item_t  cur_item;
  logic [7:0]  rd_mem [READ_DEPTH];
  logic [7:0]  rf_mem [REF_DEPTH];
  logic [7:0]  stim_ref [REF_DEPTH];
  logic [SLEN_W-1:0] cfg_slen;
  logic [THR_W-1:0]  cfg_thr;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  logic        hold_req = 1'b0;
  logic        hold_taken = 1'b0;
  int          hold_left = 0;
  int          mismatches = 0;
  int          stim_count = 0;
  int          cycle_cnt = 0;

  seed_extension_edit_checker_core DUT (
    .clk(clk), .rst(rst),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  function automatic logic [7:0] read_rd(int a);
    if (a < 0 || a >= READ_DEPTH) return SEPARATOR;
    return rd_mem[a];
  endfunction

  function automatic logic [7:0] ref_rd(int a);
    if (a < 0 || a >= REF_DEPTH) return SEPARATOR;
    return rf_mem[a];
  endfunction

  function automatic edit_kind_t edit_pick(int mis, int ins, int del, int span, int thr);
    if (mis >= ins && mis >= del && span - mis <= thr) return EDIT_MIS;
    if (ins > mis && ins > del && span - ins <= thr) return EDIT_INS;
    if (del > mis && del > ins && span - del <= thr) return EDIT_DEL;
    return EDIT_MIS;
  endfunction

  function automatic guide_t extend_seed(int rlen, int bin, int mpos);
    int slen, thr, j, k, ri, fi, l, mis, ins, del;
    int misd, insd, deld, misu, insu, delu;
    logic [7:0] rb;
    guide_t g;
    slen = int'(cfg_slen);
    thr = int'(cfg_thr);
    j = 0;
    k = 0;
    misd = 0; insd = 0; deld = 0;
    misu = 0; insu = 0; delu = 0;
    // downstream of the seed
    while (misd + insd + deld < thr && ref_rd(mpos + slen + j) != SEPARATOR) begin
      ri = bin * slen + slen + j + insd - deld;
      fi = mpos + slen + j;
      if (ri < rlen) begin
        if (read_rd(ri) != ref_rd(fi)) begin
          mis = 0; ins = 0; del = 0; l = 1;
          while (l <= LOOKAHEAD && ref_rd(fi + l) != SEPARATOR && ri + l < rlen) begin
            if (read_rd(ri + l) == ref_rd(fi + l)) mis++;
            if (read_rd(ri + l) == ref_rd(fi + l - 1)) ins++;
            if (read_rd(ri + l - 1) == ref_rd(fi + l)) del++;
            l++;
          end
          case (edit_pick(mis, ins, del, l, thr))
            EDIT_INS: insd++;
            EDIT_DEL: deld++;
            default:  misd++;
          endcase
        end
      end else begin
        misd++;
      end
      j++;
    end
    // upstream of the seed
    while (misd + misu + insd + insu + deld + delu < thr &&
           ref_rd(mpos - k - 1) != SEPARATOR) begin
      ri = bin * slen - k - 1 - insu + delu;
      fi = mpos - k - 1;
      if (ri >= 0) begin
        if (read_rd(ri) != ref_rd(fi)) begin
          mis = 0; ins = 0; del = 0; l = 0;
          while (l < LOOKAHEAD && ref_rd(fi - l) != SEPARATOR && ri - l >= 0) begin
            rb = read_rd(ri - l);
            if (rb == ref_rd(fi - l)) mis++;
            if (rb == ref_rd(fi - l + 1)) ins++;
            if (rb == ref_rd(fi - l - 1)) del++;
            l++;
          end
          case (edit_pick(mis, ins, del, l, thr))
            EDIT_INS: insu++;
            EDIT_DEL: delu++;
            default:  misu++;
          endcase
        end
      end else begin
        misu++;
      end
      k++;
    end
    g.found = (j + k > 2) && (misd + misu + insd + insu + deld + delu < thr);
    g.guide_position = g.found ? 8'(mpos) : 8'd0;
    return g;
  endfunction

  task automatic note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  // register copy follows the bus
  always @(posedge clk) begin
    if (rst) begin
      cfg_slen <= SEED_LENGTH_RST;
      cfg_thr <= EDIT_THRESHOLD_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (int'(paddr) / 4)
        REG_SEED_LENGTH:    cfg_slen <= pwdata[SLEN_W-1:0];
        REG_EDIT_THRESHOLD: cfg_thr <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // sender
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        case (cur_item.mode)
          MODE_LOAD_READ: rd_mem[cur_item.load_address] = cur_item.base_byte;
          MODE_LOAD_REF:  rf_mem[cur_item.load_address] = cur_item.base_byte;
          MODE_START: pending_guides.push_back(extend_seed(int'(cur_item.read_length),
                        int'(cur_item.seed_bin), int'(cur_item.match_position)));
          default: ;
        endcase
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (stim_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_item = stim_items.pop_front();
          s_axis_tdata <= {7'd0, cur_item.match_position, cur_item.seed_bin,
                           cur_item.read_length, cur_item.base_byte, cur_item.load_address};
          s_axis_tuser <= cur_item.mode;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver and result check
  always @(posedge clk) begin
    guide_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_guides.size() == 0) begin
          note_mismatch($sformatf("unexpected result found=%0d pos=%0d",
                                  m_axis_tuser, m_axis_tdata));
        end else begin
          want = pending_guides.pop_front();
          if (m_axis_tuser !== want.found || m_axis_tdata !== want.guide_position)
            note_mismatch($sformatf("expected found=%0d pos=%0d, got found=%0d pos=%0d",
                                    want.found, want.guide_position,
                                    m_axis_tuser, m_axis_tdata));
        end
      end
      if (hold_req && !hold_taken) begin
        hold_taken <= 1'b1;
        hold_left <= HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [7:0] rand_base();
    case ($urandom_range(0, 3))
      0: return "A";
      1: return "C";
      2: return "G";
      default: return "T";
    endcase
  endfunction

  function automatic logic [7:0] stim_ref_at(int a);
    if (a < 0 || a >= REF_DEPTH) return SEPARATOR;
    return stim_ref[a];
  endfunction

  task automatic push_item(logic [MODE_W-1:0] mode, int addr, logic [7:0] b,
                           int rlen, int bin, int mpos);
    stim_item_t it;
    it.mode = mode;
    it.load_address = 8'(addr);
    it.base_byte = b;
    it.read_length = 9'(rlen);
    it.seed_bin = 8'(bin);
    it.match_position = 8'(mpos);
    if (mode == MODE_LOAD_REF) stim_ref[it.load_address] = b;
    stim_items.push_back(it);
    stim_count++;
  endtask

  task automatic put_read(int a, logic [7:0] b);
    if (a >= 0 && a < READ_DEPTH)
      push_item(MODE_LOAD_READ, a, b, $urandom_range(0, 256), $urandom_range(0, 255),
                $urandom_range(0, 255));
  endtask

  // copy reference bases into the read, with the odd substitution, insertion or deletion
  task automatic emit_chain(int rpos, int fpos, int dir, int count, int rate);
    int n;
    logic [7:0] b;
    for (n = 0; n < count; n++) begin
      b = stim_ref_at(fpos + dir * n);
      if (b == SEPARATOR) b = rand_base();
      if ($urandom_range(0, 99) < rate) begin
        case ($urandom_range(0, 2))
          0: begin
            put_read(rpos, rand_base());
            rpos += dir;
          end
          1: begin
            put_read(rpos, b);
            put_read(rpos + dir, rand_base());
            rpos += 2 * dir;
          end
          default: ;
        endcase
      end else begin
        put_read(rpos, b);
        rpos += dir;
      end
    end
  endtask

  task automatic add_match_case(int slen);
    int mpos, bin, pre, post, rate, rlen;
    mpos = $urandom_range(0, 255);
    bin = ($urandom_range(0, 99) < 15) ? 0 : $urandom_range(0, 255 / slen);
    pre = $urandom_range(0, 10);
    post = $urandom_range(0, 14);
    rate = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 18);
    emit_chain(bin * slen + slen, mpos + slen, 1, post, rate);
    emit_chain(bin * slen - 1, mpos - 1, -1, pre, rate);
    if ($urandom_range(0, 99) < 75) rlen = 256;
    else rlen = bin * slen + slen + $urandom_range(0, post);
    if (rlen > 256) rlen = 256;
    push_item(MODE_START, $urandom_range(0, 255), $urandom_range(0, 255), rlen, bin, mpos);
  endtask

  task automatic add_noise();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        b = ($urandom_range(0, 9) < 7) ? rand_base() : 8'($urandom_range(0, 255));
        put_read($urandom_range(0, 255), b);
      end
      3, 4, 5: begin
        case ($urandom_range(0, 3))
          0, 1: b = rand_base();
          2: b = SEPARATOR;
          default: b = 8'($urandom_range(0, 255));
        endcase
        push_item(MODE_LOAD_REF, $urandom_range(0, 255), b, $urandom_range(0, 256),
                  $urandom_range(0, 255), $urandom_range(0, 255));
      end
      6: push_item(MODE_UNUSED, $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 256), $urandom_range(0, 255), $urandom_range(0, 255));
      default: push_item(MODE_START, $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 256), $urandom_range(0, 255),
                         $urandom_range(0, 255));
    endcase
  endtask

  task automatic drain();
    while (stim_items.size() != 0 || s_axis_tvalid || pending_guides.size() != 0)
      @(posedge clk);
  endtask

  task automatic reg_write(int idx, int val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_AW'(idx * 4);
    pwdata <= APB_DW'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic run_phase(int slen, int thr, int sidle, int rstall, int nitems, bit hold);
    int start_cnt;
    drain();
    repeat (SETTLE) @(posedge clk);
    reg_write(REG_SEED_LENGTH, slen);
    reg_write(REG_EDIT_THRESHOLD, thr);
    @(negedge clk);
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    if (hold) hold_req = 1'b1;
    start_cnt = stim_count;
    while (stim_count - start_cnt < nitems) begin
      if ($urandom_range(0, 99) < 70) add_match_case(slen);
      else add_noise();
    end
  endtask

  initial begin
    int pos, seg, i;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // fill both stores so no start ever reads an unwritten entry
    pos = 0;
    while (pos < REF_DEPTH) begin
      seg = $urandom_range(6, 40);
      for (i = 0; i < seg && pos < REF_DEPTH; i++) begin
        push_item(MODE_LOAD_REF, pos, rand_base(), 0, 0, 0);
        pos++;
      end
      if (pos < REF_DEPTH) push_item(MODE_LOAD_REF, pos, SEPARATOR, 0, 0, 0);
      pos++;
    end
    for (i = 0; i < READ_DEPTH; i++) push_item(MODE_LOAD_READ, i, rand_base(), 0, 0, 0);
    drain();
    @(negedge clk);
    // directed items at the reset settings
    push_item(MODE_LOAD_READ, 0, 8'h00, 0, 0, 0);
    push_item(MODE_LOAD_READ, 255, 8'hFF, 256, 255, 255);
    push_item(MODE_LOAD_REF, 255, 8'hFF, 256, 255, 255);
    push_item(MODE_LOAD_REF, 0, 8'h00, 0, 0, 0);
    push_item(MODE_UNUSED, 255, 8'hFF, 256, 255, 255);
    push_item(MODE_START, 0, 0, 256, 0, 0);
    push_item(MODE_START, 0, 0, 0, 0, 128);
    push_item(MODE_START, 255, 255, 256, 255, 255);
    push_item(MODE_START, 0, 0, 256, 51, 250);
    push_item(MODE_START, 0, 0, 3, 2, 100);
    push_item(MODE_START, 0, 0, 256, 0, 60);
    push_item(MODE_START, 0, 0, 256, 1, 200);
    push_item(MODE_START, 0, 0, 256, 40, 20);
    add_match_case(5);
    run_phase(1, 1, 0, 0, 170, 1'b0);
    run_phase(64, 15, 73, 0, 170, 1'b0);
    run_phase(8, 4, 0, 73, 170, 1'b1);
    run_phase(3, 15, 6, 6, 170, 1'b0);
    run_phase(16, 2, 0, 0, 170, 1'b0);
    run_phase(5, 0, 73, 73, 60, 1'b0);
    run_phase(7, 9, 6, 6, 170, 1'b0);
    drain();
    repeat (TAIL) @(posedge clk);
    if (pending_guides.size() != 0)
      note_mismatch($sformatf("%0d results never came", pending_guides.size()));
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/sext_pkg.sv
rtl/sext_ram.sv
rtl/sext_seq.sv
rtl/seed_extension_edit_checker_core.sv
bench/tb_seed_extension_edit_checker_core.sv
